// File: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sbc_pkg.sv
// shared constants, types and helper functions of the splitter bucket classifier
`default_nettype none

package sbc_pkg;

  localparam int NUM_SPLITTERS = 255;
  localparam int COUNT_WIDTH   = 32;
  localparam int BUCKET_COUNT  = 2 * NUM_SPLITTERS + 1;

  localparam int SPL_AW = (NUM_SPLITTERS > 1) ? $clog2(NUM_SPLITTERS) : 1;
  localparam int SPL_CW = $clog2(NUM_SPLITTERS + 1);
  localparam int CNT_AW = SPL_CW + 1;

  localparam int INDEX_W  = 9;
  localparam int KEY_W    = 64;
  localparam int BUCKET_W = 9;
  localparam int COUNT_W  = 32;
  localparam int PREFIX_W = 4;

  // command queue depth, a power of two
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  localparam logic [KEY_W-1:0]       LOW_BYTE_MASK = 64'hFF;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = '1;

  typedef enum logic [1:0] {
    MODE_LOAD     = 2'd0,
    MODE_CLASSIFY = 2'd1,
    MODE_READ     = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    logic [INDEX_W-1:0]  index;
    logic [KEY_W-1:0]    key;
    logic                load_ok;
    logic                first;
    logic                cnt_ok;
    logic                spl_ok;
  } cmd_t;

  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  count;
    logic [PREFIX_W-1:0] prefix_bytes;
    logic                terminated;
  } res_t;

  typedef struct packed {
    logic full;
    logic one;
  } rq_status_t;

  // whole leading bytes in which two keys agree
  function automatic logic [PREFIX_W-1:0] common_bytes(input logic [KEY_W-1:0] a,
                                                       input logic [KEY_W-1:0] b);
    logic [KEY_W-1:0]    diff;
    logic                run;
    logic [PREFIX_W-1:0] n;
    diff = a ^ b;
    run  = 1'b1;
    n    = '0;
    for (int i = 0; i < 8; i++) begin
      if (run && diff[KEY_W-1-8*i -: 8] == 8'h00) begin
        n = n + 1'b1;
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  // low bits of a counter as the count field
  function automatic logic [COUNT_W-1:0] to_count_field(input logic [COUNT_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/splitter_bucket_classifier.sv
// Splitter bucket classifier: loads a splitter table, classifies keys into
// less/equal buckets with saturating counters, reads buckets back and clears the counters.
// Input channel: push/full with mode, index, key; a word is taken when push is
// high and full is low. Result channel: empty/pop with bucket, count,
// prefix_bytes, terminated; every input word yields exactly one result word.
// Words pass through a four-deep command queue, a sequencer owning the
// splitter, prefix and counter memories, and a two-deep result queue.
// Sequencer work per word: load reads the previous splitter, then writes the
// key and its common prefix length; read fetches the splitter, prefix and
// counter memories, then emits the result; classify does one splitter memory
// read per search step, then a counter read-modify-write; clear zeroes one
// counter per cycle. After reset the counters are swept to zero in the same
// way; full stays high during that pass.
// When the receiver stalls, results collect in the result queue, then the
// sequencer waits, then the command queue fills and full rises; nothing is lost.
`default_nettype none

module splitter_bucket_classifier (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [1:0]                    mode,
  input  wire logic [sbc_pkg::INDEX_W-1:0]   index,
  input  wire logic [sbc_pkg::KEY_W-1:0]     key,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [sbc_pkg::BUCKET_W-1:0]       bucket,
  output logic [sbc_pkg::COUNT_W-1:0]        count,
  output logic [sbc_pkg::PREFIX_W-1:0]       prefix_bytes,
  output logic                               terminated
);

  logic                cmd_valid;
  sbc_pkg::cmd_t       cmd;
  logic                cmd_pop;
  logic                init_busy;
  sbc_pkg::rq_status_t rq;
  logic                res_push;
  sbc_pkg::res_t       res;
  sbc_pkg::res_t       head;

  sbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .index     (index),
    .key       (key),
    .init_busy (init_busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  sbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .init_busy (init_busy),
    .rq        (rq),
    .res_push  (res_push),
    .res       (res)
  );

  sbc_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .rq       (rq),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign bucket       = head.bucket;
  assign count        = head.count;
  assign prefix_bytes = head.prefix_bytes;
  assign terminated   = head.terminated;

endmodule

`default_nettype wire

// File: hw/rtl/sbc_front.sv
// front end: decodes incoming words and holds them in a short command queue
`default_nettype none
`include "assert_macros.svh"

module sbc_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [1:0]                   mode,
  input  wire logic [sbc_pkg::INDEX_W-1:0]  index,
  input  wire logic [sbc_pkg::KEY_W-1:0]    key,
  input  wire logic                         init_busy,
  output logic                              cmd_valid,
  output sbc_pkg::cmd_t                     cmd,
  input  wire logic                         cmd_pop
);

  sbc_pkg::cmd_t                 queue [sbc_pkg::CMDQ_DEPTH];
  logic [sbc_pkg::CMDQ_AW-1:0]   wr_ptr;
  logic [sbc_pkg::CMDQ_AW-1:0]   rd_ptr;
  logic [sbc_pkg::CMDQ_CW-1:0]   fill;
  logic [sbc_pkg::CMDQ_CW-1:0]   fill_next;
  logic                          accept;
  logic                          q_full;
  sbc_pkg::cmd_t                 dec;

  // range checks done once here so the back end only steers
  always_comb begin
    dec.mode    = sbc_pkg::mode_t'(mode);
    dec.index   = index;
    dec.key     = key;
    dec.load_ok = 32'(index) < sbc_pkg::NUM_SPLITTERS;
    dec.first   = index == '0;
    dec.cnt_ok  = 32'(index) < sbc_pkg::BUCKET_COUNT;
    dec.spl_ok  = (32'(index) < sbc_pkg::BUCKET_COUNT) &&
                  ((32'(index) >> 1) < sbc_pkg::NUM_SPLITTERS);
  end

  assign q_full    = fill == sbc_pkg::CMDQ_CW'(sbc_pkg::CMDQ_DEPTH);
  assign full      = q_full || init_busy;
  assign accept    = push && !full;
  assign cmd_valid = fill != '0;
  assign cmd       = queue[rd_ptr];

  always_comb begin
    fill_next = fill;
    case ({accept, cmd_pop})
      2'b10:   fill_next = fill + 1'b1;
      2'b01:   fill_next = fill - 1'b1;
      default: fill_next = fill;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      queue[wr_ptr] <= dec;
    end
  end

  `ASSERT_IMPLIES(a_pop_needs_word, clk, rst, cmd_pop, cmd_valid, "command popped from empty queue")
  `ASSERT_NEXT(a_full_holds, clk, rst, q_full && !cmd_pop, q_full, "full queue lost a word")

endmodule

`default_nettype wire

// File: hw/rtl/sbc_back.sv
// back end: sequencer with splitter, prefix and counter memories
`default_nettype none
`include "assert_macros.svh"

module sbc_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  input  wire sbc_pkg::cmd_t        cmd,
  output logic                      cmd_pop,
  output logic                      init_busy,
  input  wire sbc_pkg::rq_status_t  rq,
  output logic                      res_push,
  output sbc_pkg::res_t             res
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SEARCH,
    S_COUNT,
    S_LOAD,
    S_READ,
    S_CLEAR
  } state_t;

  localparam logic [sbc_pkg::SPL_CW-1:0] MID_FIRST =
    sbc_pkg::SPL_CW'(sbc_pkg::NUM_SPLITTERS / 2);

  state_t                          state, state_next;
  sbc_pkg::cmd_t                   cur, cur_next;
  logic [sbc_pkg::SPL_CW-1:0]      lo, lo_next;
  logic [sbc_pkg::SPL_CW-1:0]      hi, hi_next;
  logic                            eq, eq_next;
  logic [sbc_pkg::CNT_AW-1:0]      clr_addr, clr_addr_next;
  sbc_pkg::res_t                   res_next;
  logic                            res_push_next;

  logic [sbc_pkg::KEY_W-1:0]       spl_mem [sbc_pkg::NUM_SPLITTERS];
  logic [sbc_pkg::PREFIX_W-1:0]    pfx_mem [sbc_pkg::NUM_SPLITTERS];
  logic [sbc_pkg::COUNT_WIDTH-1:0] cnt_mem [sbc_pkg::BUCKET_COUNT];

  logic [sbc_pkg::SPL_AW-1:0]      spl_raddr;
  logic [sbc_pkg::KEY_W-1:0]       spl_rdata;
  logic [sbc_pkg::PREFIX_W-1:0]    pfx_rdata;
  logic                            spl_we;
  logic [sbc_pkg::PREFIX_W-1:0]    pfx_val;
  logic [sbc_pkg::CNT_AW-1:0]      cnt_raddr;
  logic [sbc_pkg::COUNT_WIDTH-1:0] cnt_rdata;
  logic                            cnt_we;
  logic [sbc_pkg::CNT_AW-1:0]      cnt_waddr;
  logic [sbc_pkg::COUNT_WIDTH-1:0] cnt_wdata;

  logic                            pop_ok;
  logic [sbc_pkg::SPL_CW-1:0]      mid, mid_s, lo_s, hi_s;
  logic                            le, eq_s;

  assign init_busy = state == S_INIT;
  // keep one result slot free for the word in flight, counting a push under way
  assign pop_ok    = !rq.full && !(res_push && rq.one);

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    lo_next       = lo;
    hi_next       = hi;
    eq_next       = eq;
    clr_addr_next = clr_addr;
    res_next      = res;
    res_push_next = 1'b0;
    cmd_pop       = 1'b0;
    spl_raddr     = sbc_pkg::SPL_AW'(MID_FIRST);
    cnt_raddr     = '0;
    spl_we        = 1'b0;
    pfx_val       = '0;
    cnt_we        = 1'b0;
    cnt_waddr     = clr_addr;
    cnt_wdata     = '0;

    // one search step: spl_rdata holds the splitter at the midpoint of lo..hi
    mid  = sbc_pkg::SPL_CW'((sbc_pkg::CNT_AW'(lo) + sbc_pkg::CNT_AW'(hi)) >> 1);
    le   = cur.key <= spl_rdata;
    lo_s = le ? lo : mid + 1'b1;
    hi_s = le ? mid : hi;
    eq_s = le ? (cur.key == spl_rdata) : eq;
    mid_s = sbc_pkg::SPL_CW'((sbc_pkg::CNT_AW'(lo_s) + sbc_pkg::CNT_AW'(hi_s)) >> 1);

    case (state)
      S_INIT, S_CLEAR: begin
        cnt_we        = 1'b1;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == sbc_pkg::CNT_AW'(sbc_pkg::BUCKET_COUNT - 1)) begin
          clr_addr_next = '0;
          state_next    = S_IDLE;
          if (state == S_CLEAR) begin
            res_next      = '0;
            res_push_next = 1'b1;
          end
        end
      end
      S_IDLE: begin
        if (cmd_valid && pop_ok) begin
          cmd_pop  = 1'b1;
          cur_next = cmd;
          lo_next  = '0;
          hi_next  = sbc_pkg::SPL_CW'(sbc_pkg::NUM_SPLITTERS);
          eq_next  = 1'b0;
          case (cmd.mode)
            sbc_pkg::MODE_LOAD: begin
              spl_raddr  = sbc_pkg::SPL_AW'(cmd.index - 1'b1);
              state_next = S_LOAD;
            end
            sbc_pkg::MODE_CLASSIFY: begin
              spl_raddr  = sbc_pkg::SPL_AW'(MID_FIRST);
              state_next = S_SEARCH;
            end
            sbc_pkg::MODE_READ: begin
              spl_raddr  = sbc_pkg::SPL_AW'(cmd.index >> 1);
              cnt_raddr  = sbc_pkg::CNT_AW'(cmd.index);
              state_next = S_READ;
            end
            sbc_pkg::MODE_CLEAR: begin
              state_next = S_CLEAR;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        spl_raddr = sbc_pkg::SPL_AW'(mid_s);
        lo_next   = lo_s;
        hi_next   = hi_s;
        eq_next   = eq_s;
        if (lo_s == hi_s) begin
          cnt_raddr  = {lo_s, eq_s};
          state_next = S_COUNT;
        end
      end
      S_COUNT: begin
        cnt_we          = 1'b1;
        cnt_waddr       = {lo, eq};
        cnt_wdata       = (cnt_rdata != sbc_pkg::COUNT_MAX) ? cnt_rdata + 1'b1 : cnt_rdata;
        res_next        = '0;
        res_next.bucket = sbc_pkg::BUCKET_W'({lo, eq});
        res_push_next   = 1'b1;
        state_next      = S_IDLE;
      end
      S_LOAD: begin
        spl_we        = cur.load_ok;
        pfx_val       = cur.first ? '0 : sbc_pkg::common_bytes(spl_rdata, cur.key);
        res_next      = '0;
        res_push_next = 1'b1;
        state_next    = S_IDLE;
      end
      S_READ: begin
        res_next.bucket       = cur.index;
        res_next.count        = cur.cnt_ok ? sbc_pkg::to_count_field(cnt_rdata) : '0;
        res_next.prefix_bytes = cur.spl_ok ? pfx_rdata : '0;
        res_next.terminated   = cur.spl_ok && ((spl_rdata & sbc_pkg::LOW_BYTE_MASK) == '0);
        res_push_next         = 1'b1;
        state_next            = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      clr_addr <= '0;
      res_push <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      res_push <= res_push_next;
    end
    cur <= cur_next;
    lo  <= lo_next;
    hi  <= hi_next;
    eq  <= eq_next;
    res <= res_next;
  end

  always_ff @(posedge clk) begin
    if (spl_we) begin
      spl_mem[sbc_pkg::SPL_AW'(cur.index)] <= cur.key;
      pfx_mem[sbc_pkg::SPL_AW'(cur.index)] <= pfx_val;
    end
    spl_rdata <= spl_mem[spl_raddr];
    pfx_rdata <= pfx_mem[spl_raddr];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  `ASSERT_IMPLIES(a_result_has_slot, clk, rst, res_push, !rq.full, "result pushed into full queue")
  `ASSERT_NEXT(a_count_after_search, clk, rst, state == S_COUNT, res_push, "classify gave no word")

endmodule

`default_nettype wire

// File: hw/rtl/sbc_res_queue.sv
// two-entry result queue between the back end and the receiver
`default_nettype none
`include "assert_macros.svh"

module sbc_res_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           res_push,
  input  wire sbc_pkg::res_t  res,
  output sbc_pkg::rq_status_t rq,
  output logic                empty,
  input  wire logic           pop,
  output sbc_pkg::res_t       head
);

  sbc_pkg::res_t slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;
  logic          take;

  assign empty   = fill == 2'd0;
  assign rq.full = fill == 2'd2;
  assign rq.one  = fill == 2'd1;
  assign take    = pop && !empty;
  assign head    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (take) begin
        rd_ptr <= !rd_ptr;
      end
      case ({res_push, take})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      slot[wr_ptr] <= res;
    end
  end

  `ASSERT_NEXT(a_push_shows_word, clk, rst, res_push && !take, !empty, "pushed word not visible")

endmodule

`default_nettype wire
